>>> hw/rtl/sgm_pkg.sv
// Shared types and constants for the Sobel gradient magnitude block.
// Used by sgm_window, sgm_isqrt and the top level sobel_gradient_magnitude.
package sgm_pkg;

  localparam int PIX_W      = 8;     // pixel intensity bits
  localparam int MAX_WIDTH  = 1024;  // longest supported row
  localparam int COL_W      = 10;    // column counter, indexes the line store
  localparam int ROW_W      = 13;    // row counter, runs one past the frame height
  localparam int WID_W      = 11;    // frame_width register
  localparam int HGT_W      = 12;    // frame_height register
  localparam int GRAD_W     = 11;    // signed Sobel gradient
  localparam int SUM_W      = 21;    // Gx^2 + Gy^2
  localparam int MAG_W      = 11;    // magnitude result
  localparam int ROOT_STEPS = 11;    // one root bit per iteration
  localparam int STEP_W     = 4;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Input opcodes.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef pix_t [2:0]               win_col_t;   // [0] top row .. [2] bottom row
  typedef logic signed [GRAD_W-1:0] grad_t;

  // Sequencing strobes from the controller to the window datapath.
  typedef struct packed {
    logic load;   // input transfer accepted: latch item, read line store
    logic step;   // line store data valid: update window and counters
    logic clear;  // configuration write: restart the frame
  } sgm_ctrl_t;

endpackage

>>> hw/rtl/sobel_gradient_magnitude.sv
// Sobel gradient magnitude, top level: configuration, sequencing, output register.
// Depends on sgm_pkg, sgm_window and sgm_isqrt.
//
// Usage: pixels of a frame enter in raster order on the s_ channel, tuser = 0 and
// the pixel in tdata. Each pixel yields floor(sqrt(Gx^2 + Gy^2)) for the pixel one
// row and one column earlier, frame edges clamped. After the last pixel of a frame
// send frame_width + 1 drain transfers (tuser = 1) to flush the final results; the
// last result of a frame carries m_tlast. Pushes after frame end and drains before
// it are accepted and dropped.
// Timing: one item is worked on at a time. A result reaches m_ after its input
// transfer passes the line store read, the window and gradients, the bit-serial
// square root and the hand-off to the output register. An item without a result
// frees the input after the window step; a dropped one does not hold it at all.
// A new item is taken only once the square root has handed off its result.
// A finished result waits in the output register while the next item is taken; if
// m_tready stays low the block holds the following result and stops accepting.
// Reset: width 640, height 480, frame restarts at row 0; the line stores are not
// cleared and hold no needed data until written. A configuration write restarts
// the frame; the user must write only while idle; the block does not enforce it.
module sobel_gradient_magnitude (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration write port.
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [sgm_pkg::HGT_W-1:0]  cfg_wdata,
  // Input stream.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] pixel
  input  logic                       s_tuser,   // [0] opcode
  // Result stream.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,   // [10:0] magnitude, [15:11] zero
  output logic                       m_tlast    // frame_end
);
  import sgm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [WID_W-1:0] frame_width;
  logic [HGT_W-1:0] frame_height;
  logic [WID_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;

  sgm_ctrl_t        ctrl;
  logic             item_ok;
  grad_t            gx;
  grad_t            gy;
  logic             due;
  logic             last;
  logic [2*GRAD_W-1:0] sq_x;
  logic [2*GRAD_W-1:0] sq_y;
  logic [SUM_W-1:0] sum;
  logic             root_start;
  logic             root_busy;
  logic [MAG_W-1:0] root;
  logic             out_load;
  logic             in_xfer;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WID_W'(640);
      frame_height <= HGT_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata[WID_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Width clamps to 1..MAX_WIDTH, height to at least 1.
  always_comb begin
    if (frame_width == '0) begin
      width_eff = WID_W'(1);
    end else if (frame_width > WID_W'(MAX_WIDTH)) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = frame_width;
    end
    height_eff = (frame_height == '0) ? HGT_W'(1) : frame_height;
  end

  assign s_tready = (state == ST_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  assign ctrl.load  = in_xfer;
  assign ctrl.step  = (state == ST_RD);
  assign ctrl.clear = cfg_we;

  sgm_window u_window (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .opcode     (s_tuser),
    .pixel      (s_tdata),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .item_ok    (item_ok),
    .gx         (gx),
    .gy         (gy),
    .due        (due),
    .last       (last)
  );

  // Sum of squares feeds the root unit's input register.
  assign sq_x       = (2*GRAD_W)'(gx) * (2*GRAD_W)'(gx);
  assign sq_y       = (2*GRAD_W)'(gy) * (2*GRAD_W)'(gy);
  assign sum        = sq_x[SUM_W-1:0] + sq_y[SUM_W-1:0];
  assign root_start = (state == ST_CHK) && due;

  sgm_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (sum),
    .busy  (root_busy),
    .root  (root)
  );

  assign out_load = (state == ST_ROOT) && !root_busy && (!m_tvalid || m_tready);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer && item_ok) state_next = ST_RD;
      ST_RD:   state_next = ST_CHK;
      ST_CHK:  state_next = due ? ST_ROOT : ST_IDLE;
      ST_ROOT: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register; a transfer empties it, a finished root refills it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'b00000, root};
      m_tlast <= last;
    end
  end

endmodule

>>> hw/rtl/sgm_window.sv
// Line store memory, 3x3 window, raster counters and Sobel gradients.
// Depends on sgm_pkg.
module sgm_window (
  input  logic                     clk,
  input  logic                     rst,
  input  sgm_pkg::sgm_ctrl_t       ctrl,
  input  logic                     opcode,
  input  sgm_pkg::pix_t            pixel,
  input  logic [sgm_pkg::WID_W-1:0] width_eff,
  input  logic [sgm_pkg::HGT_W-1:0] height_eff,
  output logic                     item_ok,
  output sgm_pkg::grad_t           gx,
  output sgm_pkg::grad_t           gy,
  output logic                     due,
  output logic                     last
);
  import sgm_pkg::*;

  // Each entry holds {row two back, row one back} for one column.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             op_q;
  pix_t             pix_q;
  win_col_t         win [3];   // [0] oldest column .. [2] newest

  logic [ROW_W-1:0] h_ext;
  logic [ROW_W-1:0] h_plus1;
  logic [WID_W-1:0] col_inc;
  logic             in_frame;
  logic             due_now;
  logic             last_now;
  pix_t             upper;
  pix_t             lower;
  win_col_t         new_col;
  win_col_t         lft;
  win_col_t         mid;
  win_col_t         rgt;

  assign h_ext   = {1'b0, height_eff};
  assign h_plus1 = h_ext + ROW_W'(1);
  assign col_inc = {1'b0, col} + WID_W'(1);

  // A push belongs inside the frame, a drain after its last row.
  always_comb begin
    if (opcode == OP_PUSH) begin
      item_ok = (row < h_ext) && ({1'b0, col} < width_eff);
    end else begin
      item_ok = (row >= h_ext) && ({1'b0, col} < width_eff);
    end
  end

  // Line store: read on accept; the step after writes back a push's shifted pair.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rd_q <= line_mem[col];
    end
    if (ctrl.step && (op_q == OP_PUSH)) begin
      line_mem[col] <= {rd_q[PIX_W-1:0], pix_q};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_q  <= opcode;
      pix_q <= pixel;
    end
  end

  // New window column with edge clamping on the top and bottom rows.
  assign upper    = rd_q[2*PIX_W-1:PIX_W];
  assign lower    = rd_q[PIX_W-1:0];
  assign in_frame = (row != '0) && (row <= h_ext);

  always_comb begin
    if (in_frame) begin
      new_col[1] = lower;
      new_col[0] = (row == ROW_W'(1)) ? lower : upper;
      new_col[2] = (op_q == OP_PUSH) ? pix_q : lower;
    end else begin
      new_col = '0;
    end
  end

  // Output for position p is due for p in [W+1, W*H+W]; the last one ends the frame.
  assign due_now  = ((row >= ROW_W'(2)) || ((row == ROW_W'(1)) && (col != '0)))
                 && ((row <= h_ext) || ((row == h_plus1) && (col == '0)));
  assign last_now = (row == h_plus1) && (col == '0);

  // Window taps. At column zero the previous row's last column is the center,
  // clamped on the right; otherwise the center is the column before the new one.
  always_comb begin
    mid = win[2];
    if (col == '0) begin
      lft = (width_eff == WID_W'(1)) ? win[2] : win[1];
      rgt = win[2];
    end else begin
      lft = (col == COL_W'(1)) ? win[2] : win[1];
      rgt = new_col;
    end
  end

  function automatic grad_t ext(input pix_t p);
    ext = grad_t'({3'b000, p});
  endfunction

  // Gradients, counters and window shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      due  <= 1'b0;
      last <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        win[k] <= '0;
      end
    end else if (ctrl.clear) begin
      col <= '0;
      row <= '0;
    end else if (ctrl.step) begin
      gx <= (ext(rgt[0]) - ext(lft[0])) + ((ext(rgt[1]) - ext(lft[1])) <<< 1)
          + (ext(rgt[2]) - ext(lft[2]));
      gy <= (ext(lft[2]) - ext(lft[0])) + ((ext(mid[2]) - ext(mid[0])) <<< 1)
          + (ext(rgt[2]) - ext(rgt[0]));
      due  <= due_now;
      last <= last_now;
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= new_col;
      if (last_now) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= width_eff) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

>>> hw/rtl/sgm_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on sgm_pkg.
module sgm_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sgm_pkg::SUM_W-1:0] value,
  output logic                      busy,
  output logic [sgm_pkg::MAG_W-1:0] root
);
  import sgm_pkg::*;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W:0]    res;
  logic [SUM_W-1:0]  bitv;
  logic [STEP_W-1:0] steps;
  logic [SUM_W:0]    trial;

  assign trial = res + {1'b0, bitv};
  assign busy  = (steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      rem   <= value;
      res   <= '0;
      bitv  <= SUM_W'(1) << (SUM_W - 1);
      steps <= STEP_W'(ROOT_STEPS);
    end else if (busy) begin
      // Try the next root bit; keep it when the remainder allows.
      if ({1'b0, rem} >= trial) begin
        rem <= rem - trial[SUM_W-1:0];
        res <= (res >> 1) + {1'b0, bitv};
      end else begin
        res <= res >> 1;
      end
      bitv  <= bitv >> 2;
      steps <= steps - STEP_W'(1);
    end
  end

  // Saturate; unreachable with 8-bit pixels.
  assign root = (|res[SUM_W:MAG_W]) ? '1 : res[MAG_W-1:0];

endmodule
